FILE: hdl/rmth_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rmth_pkg;

  localparam int CAPACITY   = 1024;
  localparam int HEAP_DEPTH = (CAPACITY + 1) / 2;
  localparam int ADDR_W     = $clog2(HEAP_DEPTH);
  localparam int SIZE_W     = $clog2(HEAP_DEPTH + 1);
  localparam int DATA_W     = 32;
  localparam int COUNT_W    = 11;
  localparam int MED_W      = 33;

  // One heap operation handed from the controller to a heap engine
  typedef struct packed {
    logic                     start;
    logic                     pop;
    logic signed [DATA_W-1:0] value;
    logic [SIZE_W-1:0]        size;
  } heap_cmd_t;

endpackage

`default_nettype wire

FILE: hdl/rmth_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rmth_in_if;
  import rmth_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

FILE: hdl/rmth_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rmth_out_if;
  import rmth_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [MED_W-1:0] median_doubled;
  logic [COUNT_W-1:0]      stored_count;
  logic                    full_rejected;

  modport source (output valid, output median_doubled, output stored_count,
                  output full_rejected, input ready);
  modport sink   (input valid, input median_doubled, input stored_count,
                  input full_rejected, output ready);
endinterface

`default_nettype wire

FILE: hdl/rmth_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rmth_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one entry, read two with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

FILE: hdl/rmth_heap.sv
`timescale 1ns / 1ps
`default_nettype none

module rmth_heap import rmth_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     is_max_i,
  input  wire heap_cmd_t                cmd_i,
  output logic                          done_o,
  output logic signed [DATA_W-1:0]      top_o
);

  localparam logic [2:0] H_IDLE = 3'd0;
  localparam logic [2:0] H_UP   = 3'd1;
  localparam logic [2:0] H_LAST = 3'd2;
  localparam logic [2:0] H_DOWN = 3'd3;
  localparam logic [2:0] H_PUT  = 3'd4;

  logic [2:0]               state_q, state_d;
  logic [ADDR_W-1:0]        idx_q, idx_d;
  logic signed [DATA_W-1:0] val_q, val_d;
  logic [SIZE_W-1:0]        n_q, n_d;
  logic                     done_q, done_d;
  logic signed [DATA_W-1:0] top_q;

  logic                     we;
  logic [ADDR_W-1:0]        waddr, ra, rb, par;
  logic signed [DATA_W-1:0] wdata, rda, rdb, best_val;
  logic [ADDR_W+1:0]        left_idx, right_idx, best_idx;
  logic [ADDR_W+2:0]        next_left;
  logic                     take_l, take_r;
  logic [SIZE_W-1:0]        size_m1;

  function automatic logic ranks_above(logic signed [DATA_W-1:0] a,
                                       logic signed [DATA_W-1:0] b, logic is_max);
    return is_max ? (a > b) : (a < b);
  endfunction

  rmth_ram #(.WIDTH(DATA_W), .DEPTH(HEAP_DEPTH)) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (ra),
    .raddr_b_i (rb),
    .rdata_a_o (rda),
    .rdata_b_o (rdb)
  );

  assign par       = (idx_q - ADDR_W'(1)) >> 1;
  assign size_m1   = cmd_i.size - SIZE_W'(1);
  assign left_idx  = {1'b0, idx_q, 1'b1};
  assign right_idx = left_idx + (ADDR_W+2)'(1);

  // Pick the child that ranks above the moving value, left first
  always_comb begin
    take_l   = ranks_above(rda, val_q, is_max_i);
    best_val = take_l ? rda : val_q;
    best_idx = left_idx;
    take_r   = ((SIZE_W+2)'(right_idx) < (SIZE_W+2)'(n_q))
               && ranks_above(rdb, best_val, is_max_i);
    if (take_r) begin
      best_val = rdb;
      best_idx = right_idx;
    end
    next_left = {best_idx, 1'b1};
  end

  // Sift sequencer: one level per cycle, hole moves, value written at the end
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    val_d   = val_q;
    n_d     = n_q;
    done_d  = 1'b0;
    we      = 1'b0;
    waddr   = idx_q;
    wdata   = val_q;
    ra      = '0;
    rb      = '0;
    unique case (state_q)
      H_IDLE: begin
        if (cmd_i.start && !cmd_i.pop) begin
          val_d = cmd_i.value;
          if (cmd_i.size == '0) begin
            we     = 1'b1;
            waddr  = '0;
            wdata  = cmd_i.value;
            done_d = 1'b1;
          end else begin
            idx_d   = ADDR_W'(cmd_i.size);
            ra      = ADDR_W'(size_m1 >> 1);
            state_d = H_UP;
          end
        end else if (cmd_i.start) begin
          if (cmd_i.size > SIZE_W'(1)) begin
            n_d     = size_m1;
            ra      = ADDR_W'(size_m1);
            idx_d   = '0;
            state_d = H_LAST;
          end else begin
            done_d = 1'b1;
          end
        end
      end
      H_UP: begin
        we = 1'b1;
        if (ranks_above(val_q, rda, is_max_i)) begin
          wdata = rda;
          idx_d = par;
          if (par == '0) begin
            state_d = H_PUT;
          end else begin
            ra = (par - ADDR_W'(1)) >> 1;
          end
        end else begin
          done_d  = 1'b1;
          state_d = H_IDLE;
        end
      end
      H_LAST: begin
        val_d = rda;
        if (n_q > SIZE_W'(1)) begin
          ra      = ADDR_W'(1);
          rb      = ADDR_W'(2);
          state_d = H_DOWN;
        end else begin
          we      = 1'b1;
          waddr   = '0;
          wdata   = rda;
          done_d  = 1'b1;
          state_d = H_IDLE;
        end
      end
      H_DOWN: begin
        we = 1'b1;
        if (take_l || take_r) begin
          wdata = best_val;
          idx_d = ADDR_W'(best_idx);
          if ((SIZE_W+3)'(next_left) < (SIZE_W+3)'(n_q)) begin
            ra = ADDR_W'(next_left);
            rb = ADDR_W'(next_left + (ADDR_W+3)'(1));
          end else begin
            state_d = H_PUT;
          end
        end else begin
          done_d  = 1'b1;
          state_d = H_IDLE;
        end
      end
      H_PUT: begin
        we      = 1'b1;
        done_d  = 1'b1;
        state_d = H_IDLE;
      end
      default: state_d = H_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Track the root in a register so the controller sees it at once
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    val_q <= val_d;
    n_q   <= n_d;
    if (we && waddr == '0) begin
      top_q <= wdata;
    end
  end

  assign done_o = done_q;
  assign top_o  = top_q;

endmodule

`default_nettype wire

FILE: hdl/running_median_two_heaps_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Payload                                          Width
// in_i     in   value                                            32 signed
// out_o    out  median_doubled / stored_count / full_rejected    33 s / 11 / 1
//
// An item is taken in idle; if a top must cross over, that top is popped
// and pushed into the other heap, then the new value is pushed. A push
// climbs and a pop descends level by level, paced by the single write and
// two read ports of each heap memory. A refused item skips the heaps.
// Reset clears the count and control state only; no clearing pass. A held
// result lets the next item in but holds it at its result until taken.

module running_median_two_heaps_top import rmth_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  rmth_in_if.sink      in_i,
  rmth_out_if.source   out_o
);

  localparam logic [2:0] C_IDLE  = 3'd0;
  localparam logic [2:0] C_POP   = 3'd1;
  localparam logic [2:0] C_PUSH1 = 3'd2;
  localparam logic [2:0] C_PUSH2 = 3'd3;
  localparam logic [2:0] C_OUT   = 3'd4;

  logic [2:0]               state_q, state_d;
  logic                     go_q, go_d;
  logic signed [DATA_W-1:0] v_q, v_d, t_q, t_d;
  logic                     sel_up_q, sel_up_d, swap_q, swap_d, full_q, full_d;
  logic [SIZE_W-1:0]        size_a_q, size_a_d, size_b_q, size_b_d;
  logic [COUNT_W-1:0]       count_q, count_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [MED_W-1:0]  med_q, med_d;
  logic [COUNT_W-1:0]       cnt_out_q, cnt_out_d;
  logic                     rej_q, rej_d;

  heap_cmd_t                cmd_a, cmd_b, cmd_up, cmd_lo;
  logic                     up_done, lo_done, done_a, done_b;
  logic signed [DATA_W-1:0] up_top, lo_top;
  logic [SIZE_W-1:0]        up_n, lo_n;
  logic                     odd, swap_now, sel_now, accept;

  rmth_heap u_upper (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .is_max_i (1'b0),
    .cmd_i    (cmd_up),
    .done_o   (up_done),
    .top_o    (up_top)
  );

  rmth_heap u_lower (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .is_max_i (1'b1),
    .cmd_i    (cmd_lo),
    .done_o   (lo_done),
    .top_o    (lo_top)
  );

  assign up_n   = SIZE_W'(({1'b0, count_q} + (COUNT_W+1)'(1)) >> 1);
  assign lo_n   = SIZE_W'(count_q >> 1);
  assign odd    = count_q[0];
  assign accept = in_i.valid && in_i.ready;

  // Decide whether a top crosses over before the new sample goes in
  assign swap_now = odd ? (up_top < in_i.value)
                        : ((lo_n != '0) && (lo_top > in_i.value));
  assign sel_now  = odd ? swap_now : !swap_now;

  assign cmd_up = sel_up_q ? cmd_a : cmd_b;
  assign cmd_lo = sel_up_q ? cmd_b : cmd_a;
  assign done_a = sel_up_q ? up_done : lo_done;
  assign done_b = sel_up_q ? lo_done : up_done;

  always_comb begin
    state_d     = state_q;
    go_d        = 1'b0;
    v_d         = v_q;
    t_d         = t_q;
    sel_up_d    = sel_up_q;
    swap_d      = swap_q;
    full_d      = full_q;
    size_a_d    = size_a_q;
    size_b_d    = size_b_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_o.ready;
    med_d       = med_q;
    cnt_out_d   = cnt_out_q;
    rej_d       = rej_q;
    cmd_a       = '0;
    cmd_b       = '0;
    unique case (state_q)
      C_IDLE: begin
        if (accept) begin
          v_d = in_i.value;
          if (count_q >= COUNT_W'(CAPACITY)) begin
            full_d  = 1'b1;
            state_d = C_OUT;
          end else begin
            full_d   = 1'b0;
            swap_d   = swap_now;
            sel_up_d = sel_now;
            t_d      = sel_now ? up_top : lo_top;
            size_a_d = sel_now ? up_n : lo_n;
            size_b_d = sel_now ? lo_n : up_n;
            go_d     = 1'b1;
            state_d  = swap_now ? C_POP : C_PUSH2;
          end
        end
      end
      C_POP: begin
        cmd_a = '{start: go_q, pop: 1'b1, value: '0, size: size_a_q};
        if (done_a) begin
          go_d    = 1'b1;
          state_d = C_PUSH1;
        end
      end
      C_PUSH1: begin
        cmd_b = '{start: go_q, pop: 1'b0, value: t_q, size: size_b_q};
        if (done_b) begin
          go_d    = 1'b1;
          state_d = C_PUSH2;
        end
      end
      C_PUSH2: begin
        cmd_a = '{start: go_q, pop: 1'b0, value: v_q,
                  size: swap_q ? size_a_q - SIZE_W'(1) : size_a_q};
        if (done_a) begin
          count_d = count_q + COUNT_W'(1);
          state_d = C_OUT;
        end
      end
      C_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          cnt_out_d   = count_q;
          rej_d       = full_q;
          if (odd) begin
            med_d = {up_top, 1'b0};
          end else begin
            med_d = {up_top[DATA_W-1], up_top} + {lo_top[DATA_W-1], lo_top};
          end
          state_d = C_IDLE;
        end
      end
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= C_IDLE;
      go_q        <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      go_q        <= go_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the transaction payload, the plan for the current item and the output result
  always_ff @(posedge clk_i) begin
    v_q       <= v_d;
    t_q       <= t_d;
    sel_up_q  <= sel_up_d;
    swap_q    <= swap_d;
    full_q    <= full_d;
    size_a_q  <= size_a_d;
    size_b_q  <= size_b_d;
    med_q     <= med_d;
    cnt_out_q <= cnt_out_d;
    rej_q     <= rej_d;
  end

  assign in_i.ready           = (state_q == C_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.median_doubled = med_q;
  assign out_o.stored_count   = cnt_out_q;
  assign out_o.full_rejected  = rej_q;

endmodule

`default_nettype wire
